// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the interpolator modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define XYSP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// expression that must never be true outside reset
`define XYSP_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);

`endif

// ===== hdl/xysp_pkg.sv =====
// ----------------------------------------------------------------------------
// xysp_pkg
// Widths, constants, segment job type and helpers of the polar interpolator.
// ----------------------------------------------------------------------------
package xysp_pkg;

    localparam int FRAC_BITS    = 8;
    localparam int ANG_BITS     = 20;
    localparam int CORDIC_ITERS = 24;
    localparam int PRESCALE_SH  = 30;
    localparam int MAX_STEPS    = 64;
    localparam int FIFO_DEPTH   = 2;

    localparam int XY_W   = 24;
    localparam int D_W    = XY_W + 1;
    localparam int Z_W    = 24;
    localparam int SL_W   = 16;
    localparam int R_W    = 24;
    localparam int A_W    = 32;
    localparam int N_W    = $clog2(MAX_STEPS + 1);
    localparam int LSQ_W  = 2 * D_W;
    localparam int LEN_W  = LSQ_W / 2;
    localparam int PSQ_W  = 2 * XY_W;
    localparam int PRD_W  = D_W + N_W + 1;
    localparam int QN_W   = PRD_W + 1;
    localparam int QD_W   = N_W + 1;
    localparam int CX_W   = 60;
    localparam int CZ_W   = 30;
    localparam int IT_W   = $clog2(CORDIC_ITERS + 1);
    localparam int RND_SH = ANG_BITS - FRAC_BITS;

    localparam logic [SL_W-1:0]          STEP_RST = SL_W'(1 << (FRAC_BITS - 1));
    localparam logic signed [CZ_W-1:0]   BASE_90  = CZ_W'(90 << ANG_BITS);
    localparam logic signed [CZ_W-1:0]   RND_HALF = CZ_W'(1 << (RND_SH - 1));
    localparam logic signed [A_W+1:0]    ANG_90   = (A_W+2)'(90 << FRAC_BITS);
    localparam logic signed [A_W+1:0]    ANG_360  = (A_W+2)'(360 << FRAC_BITS);

    typedef struct packed {
        logic signed [XY_W-1:0] px;
        logic signed [XY_W-1:0] py;
        logic signed [D_W-1:0]  dx;
        logic signed [D_W-1:0]  dy;
        logic [Z_W-1:0]         z;
        logic [N_W-1:0]         n;
    } t_job;

    // atan(2^-i) in units of 2^-20 degree
    function automatic logic signed [CZ_W-1:0] atan_lut(input logic [IT_W-1:0] i);
        logic signed [CZ_W-1:0] v;
        unique case (i)
            5'd0:  v = CZ_W'(47185920);
            5'd1:  v = CZ_W'(27855475);
            5'd2:  v = CZ_W'(14718068);
            5'd3:  v = CZ_W'(7471121);
            5'd4:  v = CZ_W'(3750058);
            5'd5:  v = CZ_W'(1876857);
            5'd6:  v = CZ_W'(938658);
            5'd7:  v = CZ_W'(469357);
            5'd8:  v = CZ_W'(234682);
            5'd9:  v = CZ_W'(117342);
            5'd10: v = CZ_W'(58671);
            5'd11: v = CZ_W'(29335);
            5'd12: v = CZ_W'(14668);
            5'd13: v = CZ_W'(7334);
            5'd14: v = CZ_W'(3667);
            5'd15: v = CZ_W'(1833);
            5'd16: v = CZ_W'(917);
            5'd17: v = CZ_W'(458);
            5'd18: v = CZ_W'(229);
            5'd19: v = CZ_W'(115);
            5'd20: v = CZ_W'(57);
            5'd21: v = CZ_W'(29);
            5'd22: v = CZ_W'(14);
            5'd23: v = CZ_W'(7);
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [A_W-1:0] sat32(input logic signed [A_W+1:0] v);
        logic signed [A_W-1:0] r;
        if (v > (A_W+2)'(64'sh7fffffff)) begin
            r = {1'b0, {(A_W-1){1'b1}}};
        end else if (v < -(A_W+2)'(64'sh80000000)) begin
            r = {1'b1, {(A_W-1){1'b0}}};
        end else begin
            r = v[A_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/xysp_isqrt.sv =====
// ----------------------------------------------------------------------------
// xysp_isqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module xysp_isqrt #(
    parameter int W = 50
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [W-1:0]   i_value,
    output logic           o_done,
    output logic [W/2-1:0] o_root
);

    localparam int CNT_W = $clog2(W / 2 + 1);

    logic [W-1:0]     r_v;
    logic [W-1:0]     r_res;
    logic [W-1:0]     r_bit;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [W-1:0]     w_trial;

    assign w_trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            if (i_start) begin
                r_v    <= i_value;
                r_res  <= '0;
                r_bit  <= W'(1) << (W - 2);
                r_cnt  <= CNT_W'(W / 2);
                r_done <= 1'b0;
            end else if (r_cnt != '0) begin
                if (r_v >= w_trial) begin
                    r_v   <= r_v - w_trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit  <= r_bit >> 2;
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == CNT_W'(1));
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[W/2-1:0];

endmodule

// ===== hdl/xysp_udiv.sv =====
// ----------------------------------------------------------------------------
// xysp_udiv
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module xysp_udiv #(
    parameter int NW = 25,
    parameter int DW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);

    localparam int CNT_W = $clog2(NW + 1);

    logic [NW-1:0]    r_num;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [DW:0]      w_shift;
    logic             w_ge;

    assign w_shift = {r_rem, r_num[NW-1]};
    assign w_ge    = (w_shift >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            if (i_start) begin
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= CNT_W'(NW);
                r_done <= 1'b0;
            end else if (r_cnt != '0) begin
                r_rem  <= w_ge ? DW'(w_shift - {1'b0, r_den}) : w_shift[DW-1:0];
                r_num  <= {r_num[NW-2:0], w_ge};
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == CNT_W'(1));
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

// ===== hdl/xysp_front.sv =====
// ----------------------------------------------------------------------------
// xysp_front
// Takes target points, measures the segment and queues a step job.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xysp_front
    import xysp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [SL_W-1:0]        i_cfg_wdata,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic signed [XY_W-1:0] i_target_x,
    input  logic signed [XY_W-1:0] i_target_y,
    input  logic signed [Z_W-1:0]  i_z_value,
    output logic                   o_push,
    output t_job                   o_job,
    input  logic                   i_full
);

    typedef enum logic [2:0] {F_IDLE, F_SQ, F_SUM, F_SQRT, F_DIV, F_PUSH} t_fstate;

    t_fstate                 r_state;
    logic [SL_W-1:0]         r_step_len;
    logic                    r_have_prev;
    logic signed [XY_W-1:0]  r_prev_x;
    logic signed [XY_W-1:0]  r_prev_y;
    t_job                    r_job;
    logic [LSQ_W-1:0]        r_sqx;
    logic [LSQ_W-1:0]        r_sqy;

    logic                    w_accept;
    logic signed [LSQ_W-1:0] w_sqx;
    logic signed [LSQ_W-1:0] w_sqy;
    logic                    w_sqrt_done;
    logic [LEN_W-1:0]        w_len;
    logic                    w_div_start;
    logic [SL_W-1:0]         w_den;
    logic                    w_div_done;
    logic [LEN_W-1:0]        w_quot;
    logic [N_W-1:0]          w_n;

    assign o_in_stall  = (r_state != F_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_sqx       = r_job.dx * r_job.dx;
    assign w_sqy       = r_job.dy * r_job.dy;
    assign w_div_start = (r_state == F_SQRT) && w_sqrt_done;
    assign w_den       = (r_step_len == '0) ? SL_W'(1) : r_step_len;
    assign w_n         = (w_quot > LEN_W'(MAX_STEPS)) ? N_W'(MAX_STEPS) : w_quot[N_W-1:0];

    xysp_isqrt #(.W(LSQ_W)) u_len_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == F_SUM),
        .i_value (r_sqx + r_sqy),
        .o_done  (w_sqrt_done),
        .o_root  (w_len)
    );

    xysp_udiv #(.NW(LEN_W), .DW(SL_W)) u_step_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_len),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= F_IDLE;
            r_step_len  <= STEP_RST;
            r_have_prev <= 1'b0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_step_len <= i_cfg_wdata;
            end
            unique case (r_state)
                F_IDLE: begin
                    if (w_accept) begin
                        r_prev_x    <= i_target_x;
                        r_prev_y    <= i_target_y;
                        r_have_prev <= 1'b1;
                        r_job.px    <= r_prev_x;
                        r_job.py    <= r_prev_y;
                        r_job.dx    <= D_W'(i_target_x) - D_W'(r_prev_x);
                        r_job.dy    <= D_W'(i_target_y) - D_W'(r_prev_y);
                        r_job.z     <= i_z_value;
                        if (r_have_prev) begin
                            r_state <= F_SQ;
                        end
                    end
                end
                F_SQ: begin
                    r_sqx   <= unsigned'(w_sqx);
                    r_sqy   <= unsigned'(w_sqy);
                    r_state <= F_SUM;
                end
                F_SUM: begin
                    r_state <= F_SQRT;
                end
                F_SQRT: begin
                    if (w_sqrt_done) begin
                        r_state <= F_DIV;
                    end
                end
                F_DIV: begin
                    if (w_div_done) begin
                        r_job.n <= w_n;
                        r_state <= (w_n == '0) ? F_IDLE : F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    assign o_push = (r_state == F_PUSH) && !i_full;
    assign o_job  = r_job;

    `XYSP_ASSERT(a_push_nonzero, o_push |-> (o_job.n != '0), "job with zero steps queued")

endmodule

// ===== hdl/xysp_fifo.sv =====
// ----------------------------------------------------------------------------
// xysp_fifo
// Short register queue of step jobs between front and back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xysp_fifo
    import xysp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_job             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

    `XYSP_NEVER(a_no_overflow, i_push && o_full, "push into full job queue")
    `XYSP_NEVER(a_no_underflow, i_pop && o_empty, "pop from empty job queue")

endmodule

// ===== hdl/xysp_back.sv =====
// ----------------------------------------------------------------------------
// xysp_back
// Walks the steps of a job: point, radius, CORDIC angle, unwrap, output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xysp_back
    import xysp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_empty,
    input  t_job                   i_job,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic signed [Z_W-1:0]  o_z_out,
    output logic [R_W-1:0]         o_radius,
    output logic signed [A_W-1:0]  o_angle_deg,
    output logic                   o_last
);

    typedef enum logic [3:0] {
        B_IDLE, B_MUL, B_DSTART, B_DIV, B_SQ, B_CALC, B_RUN, B_FIN, B_WRAP, B_OUT
    } t_bstate;

    t_bstate                  r_state;
    t_job                     r_job;
    logic [N_W-1:0]           r_k;
    logic signed [PRD_W-1:0]  r_prx;
    logic signed [PRD_W-1:0]  r_pry;
    logic signed [XY_W-1:0]   r_px;
    logic signed [XY_W-1:0]   r_py;
    logic [PSQ_W-1:0]         r_sqx;
    logic [PSQ_W-1:0]         r_sqy;
    logic signed [CX_W-1:0]   r_cx;
    logic signed [CX_W-1:0]   r_cy;
    logic signed [CZ_W-1:0]   r_cz;
    logic [IT_W-1:0]          r_it;
    logic                     r_rad_ok;
    logic [R_W-1:0]           r_radius;
    logic signed [A_W-1:0]    r_a;
    logic signed [A_W-1:0]    r_prev_angle;
    logic signed [A_W-1:0]    r_offset;
    logic                     r_out_valid;
    logic signed [Z_W-1:0]    r_out_z;
    logic [R_W-1:0]           r_out_radius;
    logic signed [A_W-1:0]    r_out_angle;
    logic                     r_out_last;

    logic signed [PRD_W-1:0]  w_prodx;
    logic signed [PRD_W-1:0]  w_prody;
    logic signed [PRD_W-1:0]  w_magx;
    logic signed [PRD_W-1:0]  w_magy;
    logic [QN_W-1:0]          w_numx;
    logic [QN_W-1:0]          w_numy;
    logic [QD_W-1:0]          w_den;
    logic                     w_dstart;
    logic                     w_donex;
    logic                     w_doney;
    logic [QN_W-1:0]          w_qx;
    logic [QN_W-1:0]          w_qy;
    logic signed [QN_W:0]     w_offx;
    logic signed [QN_W:0]     w_offy;
    logic signed [QN_W:0]     w_pxs;
    logic signed [QN_W:0]     w_pys;
    logic signed [PSQ_W-1:0]  w_sqx;
    logic signed [PSQ_W-1:0]  w_sqy;
    logic                     w_sqrt_done;
    logic [R_W-1:0]           w_root;
    logic signed [CX_W-1:0]   w_x0;
    logic signed [CX_W-1:0]   w_y0;
    logic signed [CX_W-1:0]   w_xr;
    logic signed [CX_W-1:0]   w_yr;
    logic signed [CZ_W-1:0]   w_base;
    logic signed [CX_W-1:0]   w_xs;
    logic signed [CX_W-1:0]   w_ys;
    logic signed [CZ_W-1:0]   w_atan;
    logic signed [CZ_W-1:0]   w_deg;
    logic signed [A_W+1:0]    w_a_ext;
    logic                     w_wrap;
    logic                     w_out_free;

    assign w_prodx  = r_job.dx * $signed({1'b0, r_k});
    assign w_prody  = r_job.dy * $signed({1'b0, r_k});
    assign w_magx   = r_prx[PRD_W-1] ? -r_prx : r_prx;
    assign w_magy   = r_pry[PRD_W-1] ? -r_pry : r_pry;
    assign w_numx   = QN_W'({w_magx, 1'b0}) + QN_W'(r_job.n);
    assign w_numy   = QN_W'({w_magy, 1'b0}) + QN_W'(r_job.n);
    assign w_den    = {r_job.n, 1'b0};
    assign w_dstart = (r_state == B_DSTART);

    xysp_udiv #(.NW(QN_W), .DW(QD_W)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_num   (w_numx),
        .i_den   (w_den),
        .o_done  (w_donex),
        .o_quot  (w_qx)
    );

    xysp_udiv #(.NW(QN_W), .DW(QD_W)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_num   (w_numy),
        .i_den   (w_den),
        .o_done  (w_doney),
        .o_quot  (w_qy)
    );

    // rounded quotient carries the sign of the product
    assign w_offx = r_prx[PRD_W-1] ? -$signed({1'b0, w_qx}) : $signed({1'b0, w_qx});
    assign w_offy = r_pry[PRD_W-1] ? -$signed({1'b0, w_qy}) : $signed({1'b0, w_qy});
    assign w_pxs  = (QN_W+1)'(r_job.px) + w_offx;
    assign w_pys  = (QN_W+1)'(r_job.py) + w_offy;

    assign w_sqx  = r_px * r_px;
    assign w_sqy  = r_py * r_py;

    xysp_isqrt #(.W(PSQ_W)) u_rad_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == B_CALC),
        .i_value (r_sqx + r_sqy),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    // fold the left half plane into the right by a quarter turn
    assign w_x0 = CX_W'(r_px);
    assign w_y0 = CX_W'(r_py);
    always_comb begin
        w_xr   = w_x0;
        w_yr   = w_y0;
        w_base = '0;
        if (r_px < 0) begin
            if (r_py >= 0) begin
                w_xr   = w_y0;
                w_yr   = -w_x0;
                w_base = BASE_90;
            end else begin
                w_xr   = -w_y0;
                w_yr   = w_x0;
                w_base = -BASE_90;
            end
        end
    end

    assign w_xs   = r_cx >>> r_it;
    assign w_ys   = r_cy >>> r_it;
    assign w_atan = atan_lut(r_it);
    assign w_deg  = (r_cz + RND_HALF) >>> RND_SH;

    assign w_a_ext    = (A_W+2)'(r_a);
    assign w_wrap     = ((A_W+2)'(r_prev_angle) > w_a_ext + ANG_90);
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign o_pop = (r_state == B_IDLE) && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= B_IDLE;
            r_prev_angle <= '0;
            r_offset     <= '0;
            r_out_valid  <= 1'b0;
            r_rad_ok     <= 1'b0;
            r_k          <= '0;
        end else begin
            if ((r_state == B_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_sqrt_done) begin
                r_radius <= w_root;
                r_rad_ok <= 1'b1;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_job   <= i_job;
                        r_k     <= N_W'(1);
                        r_state <= B_MUL;
                    end
                end
                B_MUL: begin
                    r_prx   <= w_prodx;
                    r_pry   <= w_prody;
                    r_state <= B_DSTART;
                end
                B_DSTART: begin
                    r_state <= B_DIV;
                end
                B_DIV: begin
                    if (w_donex && w_doney) begin
                        r_px    <= w_pxs[XY_W-1:0];
                        r_py    <= w_pys[XY_W-1:0];
                        r_state <= B_SQ;
                    end
                end
                B_SQ: begin
                    r_sqx    <= unsigned'(w_sqx);
                    r_sqy    <= unsigned'(w_sqy);
                    r_cx     <= w_xr <<< PRESCALE_SH;
                    r_cy     <= w_yr <<< PRESCALE_SH;
                    r_cz     <= w_base;
                    r_it     <= '0;
                    r_rad_ok <= 1'b0;
                    r_state  <= B_CALC;
                end
                B_CALC: begin
                    r_state <= B_RUN;
                end
                B_RUN: begin
                    if (r_it != IT_W'(CORDIC_ITERS)) begin
                        if (r_cy > 0) begin
                            r_cx <= r_cx + w_ys;
                            r_cy <= r_cy - w_xs;
                            r_cz <= r_cz + w_atan;
                        end else if (r_cy < 0) begin
                            r_cx <= r_cx - w_ys;
                            r_cy <= r_cy + w_xs;
                            r_cz <= r_cz - w_atan;
                        end
                        r_it <= r_it + 1'b1;
                    end else if (r_rad_ok) begin
                        r_state <= B_FIN;
                    end
                end
                B_FIN: begin
                    r_a     <= sat32((A_W+2)'(w_deg) + (A_W+2)'(r_offset));
                    r_state <= B_WRAP;
                end
                B_WRAP: begin
                    if (w_wrap) begin
                        r_offset <= sat32((A_W+2)'(r_offset) + ANG_360);
                        r_a      <= sat32(w_a_ext + ANG_360);
                    end
                    r_state <= B_OUT;
                end
                B_OUT: begin
                    if (w_out_free) begin
                        r_prev_angle <= r_a;
                        r_out_z      <= r_job.z;
                        r_out_radius <= r_radius;
                        r_out_angle  <= r_a;
                        r_out_last   <= (r_k == r_job.n);
                        if (r_k == r_job.n) begin
                            r_state <= B_IDLE;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= B_MUL;
                        end
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_z_out     = r_out_z;
    assign o_radius    = r_out_radius;
    assign o_angle_deg = r_out_angle;
    assign o_last      = r_out_last;

    `XYSP_ASSERT(a_step_range, (r_state != B_IDLE) |-> (r_k != '0 && r_k <= r_job.n),
        "step index outside segment")

endmodule

// ===== hdl/xy_segment_to_polar_interpolator.sv =====
// ----------------------------------------------------------------------------
// xy_segment_to_polar_interpolator
// Splits XY segments into equal steps and emits z, radius and unwrapped angle.
// ----------------------------------------------------------------------------
// channel   dir  handshake                 words
// input     in   i_in_valid / o_in_stall   target_x, target_y, z_value
// output    out  o_out_valid / i_out_stall z_out, radius, angle_deg, last
// config    in   i_cfg_we                  step_length
//
// Front: for each point, the length square root, then the step divide; a segment
// with no steps queues no job, and the first point is only stored and emits nothing.
// Back: for each step, the rounding divide, then the 24-iteration CORDIC running
// beside the radius square root, then unwrap and output; each step finishes before
// the next begins. A two-entry job queue sits between the parts.
// Synchronous active-low reset; step_length resets to 0.5.
// Output stall holds the output word; the back waits, the front fills the queue.
// ----------------------------------------------------------------------------
module xy_segment_to_polar_interpolator
    import xysp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [SL_W-1:0]        i_cfg_wdata,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic signed [XY_W-1:0] i_target_x,
    input  logic signed [XY_W-1:0] i_target_y,
    input  logic signed [Z_W-1:0]  i_z_value,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic signed [Z_W-1:0]  o_z_out,
    output logic [R_W-1:0]         o_radius,
    output logic signed [A_W-1:0]  o_angle_deg,
    output logic                   o_last
);

    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_empty;
    t_job w_job_in;
    t_job w_job_out;

    xysp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_target_x  (i_target_x),
        .i_target_y  (i_target_y),
        .i_z_value   (i_z_value),
        .o_push      (w_push),
        .o_job       (w_job_in),
        .i_full      (w_full)
    );

    xysp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_job   (w_job_out),
        .o_empty (w_empty)
    );

    xysp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_job       (w_job_out),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_z_out     (o_z_out),
        .o_radius    (o_radius),
        .o_angle_deg (o_angle_deg),
        .o_last      (o_last)
    );

endmodule
